### rtl/core/mexp_pkg.sv
package mexp_pkg;

   // Fixed field widths of the transactions.
   localparam int BASE_W  = 16;
   localparam int EXP_W   = 32;
   localparam int OPER_W  = 32;
   localparam int CNT_W   = $clog2(OPER_W);

   localparam logic [OPER_W-1:0] MODULUS_RESET = 32'd19211;
   localparam logic [OPER_W-1:0] MODULUS_MIN   = 32'd2;
   localparam logic [OPER_W-1:0] OPER_ONE      = 32'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_MUL,
      ST_SQR,
      ST_OUT
   } mexp_state_type;

   // Launch of one modular multiply: product = x_opd * y_opd mod modulus.
   typedef struct packed {
      logic              start;
      logic [OPER_W-1:0] x_opd;
      logic [OPER_W-1:0] y_opd;
   } mexp_mul_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mexp_mul_sts_type;

endpackage

### rtl/core/mexp_if.sv
interface mexp_req_if;
   import mexp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BASE_W-1:0] base;
   logic [EXP_W-1:0]  exponent;
   modport source (output valid, output base, output exponent, input ready);
   modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if;
   import mexp_pkg::*;
   logic              valid;
   logic              ready;
   logic [OPER_W-1:0] power_result;
   modport source (output valid, output power_result, input ready);
   modport sink (input valid, input power_result, output ready);
endinterface

interface mexp_csr_if;
   import mexp_pkg::*;
   logic              valid;
   logic              ready;
   logic [OPER_W-1:0] modulus;
   modport source (output valid, output modulus, input ready);
   modport sink (input valid, input modulus, output ready);
endinterface

### rtl/core/mexp_modmul.sv
module mexp_modmul (
   input  logic                            clock,
   input  logic                            reset,
   input  mexp_pkg::mexp_mul_cmd_type      cmd,
   input  logic [mexp_pkg::OPER_W-1:0]     modulus,
   output mexp_pkg::mexp_mul_sts_type      sts,
   output logic [mexp_pkg::OPER_W-1:0]     product
);
   import mexp_pkg::*;

   // Interleaved multiply and reduce, one bit of x per cycle, MSB first.
   // y must already be below the modulus, which keeps the remainder below it.
   logic [OPER_W-1:0] x_ff, x_in;
   logic [OPER_W-1:0] y_ff, y_in;
   logic [OPER_W-1:0] r_ff, r_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [OPER_W+1:0] sum;
   logic [OPER_W+2:0] diff_one;
   logic [OPER_W+2:0] diff_two;
   logic [OPER_W-1:0] r_step;

   always_comb begin
      sum      = {1'b0, r_ff, 1'b0} + {2'b00, (x_ff[OPER_W-1] ? y_ff : '0)};
      diff_one = {1'b0, sum} - {3'b000, modulus};
      diff_two = {1'b0, sum} - {2'b00, modulus, 1'b0};
      if (!diff_two[OPER_W+2]) begin
         r_step = diff_two[OPER_W-1:0];
      end else if (!diff_one[OPER_W+2]) begin
         r_step = diff_one[OPER_W-1:0];
      end else begin
         r_step = sum[OPER_W-1:0];
      end
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start && !busy_ff) begin
         x_in    = cmd.x_opd;
         y_in    = cmd.y_opd;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in   = {x_ff[OPER_W-2:0], 1'b0};
         r_in   = r_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(OPER_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      r_ff <= r_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = r_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("multiply launched while busy");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff || done_ff) |-> (r_ff < modulus))
      else $error("partial remainder not below modulus");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == CNT_W'(OPER_W - 1)) |=> (done_ff && !busy_ff))
      else $error("multiply did not finish after its last bit");
`endif

endmodule

### rtl/core/modular_exponentiation.sv
// Modular exponentiation: each request transaction carries a 16-bit base and a 32-bit exponent,
// and gives one response transaction holding base to the power exponent, modulo the modulus
// register (reset value 19211; a write below 2 is ignored). An exponent of zero returns 1.
// Only the low EXP_BITS exponent bits are used. The exponent is scanned from its least
// significant bit, with a multiply for every set bit and a square for every bit below the
// highest set one. All the arithmetic runs through one bit-serial modular multiplier; its
// first multiply of each transaction reduces the base. One transaction is worked on at a
// time. A new request is taken as soon as the previous result has been placed in the
// response register, even while that result still waits to be taken. The modulus may be
// written only while no transaction is in progress.
module modular_exponentiation #(
   parameter int EXP_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   mexp_req_if.sink   req_chan,
   mexp_rsp_if.source rsp_chan,
   mexp_csr_if.sink   csr_chan
);
   import mexp_pkg::*;

   // Working registers of the square-and-multiply sequence.
   mexp_state_type    state_ff, state_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [OPER_W-1:0] acc_ff, acc_in;
   logic [OPER_W-1:0] sq_ff, sq_in;
   logic [OPER_W-1:0] modulus_ff, modulus_in;

   // Response holding register, so the sequencer can move on while the result waits.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OPER_W-1:0] rsp_data_ff, rsp_data_in;

   mexp_mul_cmd_type  mul_cmd;
   mexp_mul_sts_type  mul_sts;
   logic [OPER_W-1:0] mul_product;

   logic req_take;
   logic rsp_free;

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign req_take          = req_chan.valid && req_chan.ready;
   assign rsp_free          = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.power_result = rsp_data_ff;

   // A modulus below two would make the reduction meaningless, so such writes are dropped.
   always_comb begin
      modulus_in = modulus_ff;
      if (csr_chan.valid && csr_chan.ready && (csr_chan.modulus >= MODULUS_MIN)) begin
         modulus_in = csr_chan.modulus;
      end
   end

   // Sequencer. The base is first reduced by multiplying it by one, so that the
   // multiplier always sees a multiplicand below the modulus.
   always_comb begin
      state_in      = state_ff;
      exp_in        = exp_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      mul_cmd.start = 1'b0;
      mul_cmd.x_opd = sq_ff;
      mul_cmd.y_opd = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            mul_cmd.x_opd = {{(OPER_W - BASE_W){1'b0}}, req_chan.base};
            mul_cmd.y_opd = OPER_ONE;
            if (req_take) begin
               mul_cmd.start = 1'b1;
               exp_in        = req_chan.exponent[EXP_BITS-1:0];
               acc_in        = OPER_ONE;
               state_in      = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mul_sts.done) begin
               sq_in    = mul_product;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (exp_ff == '0) begin
               state_in = ST_OUT;
            end else if (exp_ff[0]) begin
               mul_cmd.start = 1'b1;
               mul_cmd.x_opd = acc_ff;
               state_in      = ST_MUL;
            end else begin
               mul_cmd.start = 1'b1;
               state_in      = ST_SQR;
            end
         end
         ST_MUL: begin
            if (mul_sts.done) begin
               acc_in = mul_product;
               // Once no higher exponent bit is set, the further squares are not needed.
               if (exp_ff[EXP_BITS-1:1] == '0) begin
                  state_in = ST_OUT;
               end else begin
                  mul_cmd.start = 1'b1;
                  state_in      = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            if (mul_sts.done) begin
               sq_in    = mul_product;
               exp_in   = {1'b0, exp_ff[EXP_BITS-1:1]};
               state_in = ST_STEP;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      rsp_data_ff <= rsp_data_in;
   end

   mexp_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .modulus (modulus_ff),
      .sts     (mul_sts),
      .product (mul_product)
   );

`ifndef SYNTHESIS
   a_modulus_min: assert property (@(posedge clock) disable iff (reset)
      modulus_ff >= MODULUS_MIN)
      else $error("modulus register below two");

   a_mul_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE || state_ff == ST_MUL || state_ff == ST_SQR)
         |-> (mul_sts.busy || mul_sts.done))
      else $error("sequencer waits on an idle multiplier");

   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (acc_ff < modulus_ff))
      else $error("result not reduced below modulus");
`endif

endmodule
